>>> hw/rtl/slbs_pkg.sv
`default_nettype none

package slbs_pkg;

    // item kind
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // two-bit status codes, 2 and 3 hold the output, but low power overrides the gps codes
    localparam logic [1:0] LINK_DOWN   = 2'd0;
    localparam logic [1:0] LINK_UP     = 2'd1;
    localparam logic [1:0] GPS_NOFIX   = 2'd0;
    localparam logic [1:0] GPS_FIX     = 2'd1;
    localparam logic [1:0] LOGIN_OUT   = 2'd0;
    localparam logic [1:0] LOGIN_IN    = 2'd1;
    localparam logic [1:0] PASS_VACANT = 2'd0;
    localparam logic [1:0] PASS_HIRED  = 2'd1;

    localparam int          PHASE_W            = 3;
    localparam int          LEVEL_W            = 3;
    localparam logic [2:0]  BUZZER_LEVEL_RESET = 3'd5;
    localparam logic [2:0]  OVERSPEED_PERIOD   = 3'd7;

    typedef enum logic [2:0] {
        PAT_IDLE      = 3'd0,
        PAT_STARTING  = 3'd1,
        PAT_STARTED   = 3'd2,
        PAT_OVERSPEED = 3'd3,
        PAT_OVERTIME  = 3'd4,
        PAT_LOGIN     = 3'd5,
        PAT_LOGOUT    = 3'd6
    } pattern_t;

    typedef struct packed {
        logic       func;
        logic [2:0] pattern;
        logic [1:0] passenger_state;
        logic [1:0] link_state;
        logic       sim_missing;
        logic       internet_up;
        logic [1:0] gps_state;
        logic       low_power;
        logic [1:0] login_state;
        logic       test_mode;
    } item_t;

endpackage

`default_nettype wire

>>> hw/rtl/status_led_buzzer_sequencer_top.sv
`default_nettype none

// channel   direction  handshake            payload
// in        input      in_valid / in_stall  func, pattern, status fields
// out       output     out_valid / out_stall link_led .. hired_power
// cfg       input      cfg_valid / cfg_ready cfg_data (buzzer level)
//
// one item per cycle while out_stall is low; an accepted transaction reaches
// the output through the input register, then the result register
// the result register holds the led/buzzer/power state itself, so each
// result is the state as it stands after its item
// reset: phases 0, started chirp armed, all outputs off, buzzer level 5
// out_stall holds the result register and backs up through the input
// register to in_stall; cfg_ready is always high

module status_led_buzzer_sequencer_top
    import slbs_pkg::*;
#(
    parameter int LONG_PERIOD = 71
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               func,
    input  wire logic [2:0]         pattern,
    input  wire logic [1:0]         passenger_state,
    input  wire logic [1:0]         link_state,
    input  wire logic               sim_missing,
    input  wire logic               internet_up,
    input  wire logic [1:0]         gps_state,
    input  wire logic               low_power,
    input  wire logic [1:0]         login_state,
    input  wire logic               test_mode,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    link_led,
    output logic                    gps_led,
    output logic                    driver_led,
    output logic                    buzzer_on,
    output logic                    hired_power,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LEVEL_W-1:0] cfg_data
);

    localparam int         LW        = $clog2(LONG_PERIOD);
    localparam logic [LW-1:0] LONG_LAST = LW'(LONG_PERIOD - 1);

    // input register
    logic  s1_valid_reg, s1_valid_next;
    item_t s1_item_reg;
    logic  in_take;
    logic  advance;

    // state
    logic [LEVEL_W-1:0] level_reg;
    logic [PHASE_W-1:0] blink_phase_reg, blink_phase_next;
    logic [PHASE_W-1:0] chirp_phase_reg, chirp_phase_next;
    logic [LW-1:0]      long_phase_reg, long_phase_next;
    logic [2:0]         mod7_reg, mod7_next;     // long phase mod 7
    pattern_t           pattern_reg, pattern_next;
    logic               link_led_reg, link_led_next;
    logic               gps_led_reg, gps_led_next;
    logic               driver_led_reg, driver_led_next;
    logic               buzzer_reg, buzzer_next;
    logic               power_reg, power_next;
    logic               out_valid_reg, out_valid_next;

    logic               blink_lit;

    // handshake
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= '{func:            func,
                             pattern:         pattern,
                             passenger_state: passenger_state,
                             link_state:      link_state,
                             sim_missing:     sim_missing,
                             internet_up:     internet_up,
                             gps_state:       gps_state,
                             low_power:       low_power,
                             login_state:     login_state,
                             test_mode:       test_mode};
        end
    end

    assign blink_lit = ~blink_phase_reg[0];

    // per-item update
    always_comb
    begin
        blink_phase_next = blink_phase_reg;
        chirp_phase_next = chirp_phase_reg;
        long_phase_next  = long_phase_reg;
        mod7_next        = mod7_reg;
        pattern_next     = pattern_reg;
        link_led_next    = link_led_reg;
        gps_led_next     = gps_led_reg;
        driver_led_next  = driver_led_reg;
        buzzer_next      = buzzer_reg;
        power_next       = power_reg;

        if (s1_item_reg.func == FUNC_LOAD)
        begin
            // command: restart chirp and arm the new pattern
            chirp_phase_next = '0;
            pattern_next     = pattern_t'(s1_item_reg.pattern);
        end
        else
        begin
            if (s1_item_reg.passenger_state == PASS_VACANT)
                power_next = 1'b0;
            else if (s1_item_reg.passenger_state == PASS_HIRED)
                power_next = 1'b1;

            if (s1_item_reg.link_state == LINK_DOWN)
            begin
                if (s1_item_reg.sim_missing)
                    link_led_next = (long_phase_reg == LW'(0)) || (long_phase_reg == LW'(2));
                else if (s1_item_reg.internet_up)
                    link_led_next = 1'b1;
                else
                    link_led_next = (long_phase_reg == LW'(0)) || (long_phase_reg == LW'(2))
                                    || (long_phase_reg == LW'(4));
            end
            else if (s1_item_reg.link_state == LINK_UP)
            begin
                link_led_next = blink_lit;
            end

            if (s1_item_reg.low_power)
                gps_led_next = (s1_item_reg.gps_state == GPS_FIX)
                               && (blink_phase_reg == PHASE_W'(1));
            else if (s1_item_reg.gps_state == GPS_FIX)
                gps_led_next = blink_lit;
            else if (s1_item_reg.gps_state == GPS_NOFIX)
                gps_led_next = 1'b1;

            if (s1_item_reg.login_state == LOGIN_OUT)
                driver_led_next = 1'b0;
            else if (s1_item_reg.login_state == LOGIN_IN)
                driver_led_next = blink_lit;

            // buzzer patterns, frozen while the level is zero
            if (level_reg != '0)
            begin
                case (pattern_reg)
                    PAT_IDLE:
                    begin
                        if (!s1_item_reg.test_mode)
                            buzzer_next = 1'b0;
                    end
                    PAT_STARTING, PAT_LOGIN:
                    begin
                        if (chirp_phase_reg inside {3'd0, 3'd1, 3'd2})
                            buzzer_next = 1'b1;
                        else if (chirp_phase_reg == 3'd3)
                        begin
                            buzzer_next  = 1'b0;
                            pattern_next = PAT_IDLE;
                        end
                    end
                    PAT_STARTED:
                    begin
                        if (chirp_phase_reg inside {3'd0, 3'd2})
                            buzzer_next = 1'b1;
                        else if (chirp_phase_reg == 3'd1)
                            buzzer_next = 1'b0;
                        else if (chirp_phase_reg == 3'd3)
                        begin
                            buzzer_next  = 1'b0;
                            pattern_next = PAT_IDLE;
                        end
                    end
                    PAT_OVERSPEED:
                    begin
                        buzzer_next = (mod7_reg == 3'd0);
                    end
                    PAT_OVERTIME:
                    begin
                        buzzer_next = (long_phase_reg == LW'(0)) || (long_phase_reg == LW'(2))
                                      || (long_phase_reg == LW'(4))
                                      || (long_phase_reg == LW'(6));
                    end
                    PAT_LOGOUT:
                    begin
                        if (chirp_phase_reg inside {3'd0, 3'd2, 3'd4})
                            buzzer_next = 1'b1;
                        else if (chirp_phase_reg inside {3'd1, 3'd3})
                            buzzer_next = 1'b0;
                        else if (chirp_phase_reg == 3'd5)
                        begin
                            buzzer_next  = 1'b0;
                            pattern_next = PAT_IDLE;
                        end
                    end
                    default:
                    begin
                        // unknown pattern holds the buzzer
                    end
                endcase
            end

            // phase counters
            blink_phase_next = blink_phase_reg + PHASE_W'(1);
            chirp_phase_next = chirp_phase_reg + PHASE_W'(1);
            if (long_phase_reg == LONG_LAST)
            begin
                long_phase_next = '0;
                mod7_next       = 3'd0;
            end
            else
            begin
                long_phase_next = long_phase_reg + LW'(1);
                mod7_next       = (mod7_reg == OVERSPEED_PERIOD - 3'd1) ? 3'd0
                                                                        : mod7_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= BUZZER_LEVEL_RESET;
            blink_phase_reg <= '0;
            chirp_phase_reg <= '0;
            long_phase_reg  <= '0;
            mod7_reg        <= 3'd0;
            pattern_reg     <= PAT_STARTED;
            link_led_reg    <= 1'b0;
            gps_led_reg     <= 1'b0;
            driver_led_reg  <= 1'b0;
            buzzer_reg      <= 1'b0;
            power_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                level_reg <= cfg_data;
            if (advance)
            begin
                blink_phase_reg <= blink_phase_next;
                chirp_phase_reg <= chirp_phase_next;
                long_phase_reg  <= long_phase_next;
                mod7_reg        <= mod7_next;
                pattern_reg     <= pattern_next;
                link_led_reg    <= link_led_next;
                gps_led_reg     <= gps_led_next;
                driver_led_reg  <= driver_led_next;
                buzzer_reg      <= buzzer_next;
                power_reg       <= power_next;
            end
        end
    end

    // result register is the output state itself
    assign out_valid   = out_valid_reg;
    assign link_led    = link_led_reg;
    assign gps_led     = gps_led_reg;
    assign driver_led  = driver_led_reg;
    assign buzzer_on   = buzzer_reg;
    assign hired_power = power_reg;

    // long phase never reaches the period
    assert property (@(posedge clk) disable iff (!rst_n)
        long_phase_reg <= LONG_LAST)
        else $error("long phase out of range");

    // overspeed helper stays below the overspeed period
    assert property (@(posedge clk) disable iff (!rst_n)
        mod7_reg < OVERSPEED_PERIOD)
        else $error("mod 7 phase out of range");

    // a command transaction restarts the chirp phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.func == FUNC_LOAD) |=> (chirp_phase_reg == '0))
        else $error("chirp phase not restarted by command");

    // a held result keeps its values while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(buzzer_reg)
                                          && $stable(link_led_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
    import slbs_pkg::*;

    localparam int LONG_PERIOD = 71;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 60;
    localparam int GAP_PCT     = 6;
    localparam int PRINT_CAP   = 50;
    localparam int ITEM_W      = $bits(item_t);

    // pattern code with no meaning, must hold the buzzer
    localparam logic [2:0] PAT_UNDEFINED = 3'd7;
    // status codes that hold their output
    localparam logic [1:0] CODE_RSVD2 = 2'd2;
    localparam logic [1:0] CODE_RSVD3 = 2'd3;

    // one result transaction: the output registers after the item
    typedef struct packed {
        logic link_led;
        logic gps_led;
        logic driver_led;
        logic buzzer_on;
        logic hired_power;
    } indicators_t;

    // ------------------------------------------------------------------
    // clock and dut signals
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    logic               in_valid = 1'b0;
    logic               in_stall;
    item_t              offer = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    indicators_t        seen;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LEVEL_W-1:0] cfg_data = '0;

    status_led_buzzer_sequencer_top #(
        .LONG_PERIOD(LONG_PERIOD)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (offer.func),
        .pattern        (offer.pattern),
        .passenger_state(offer.passenger_state),
        .link_state     (offer.link_state),
        .sim_missing    (offer.sim_missing),
        .internet_up    (offer.internet_up),
        .gps_state      (offer.gps_state),
        .low_power      (offer.low_power),
        .login_state    (offer.login_state),
        .test_mode      (offer.test_mode),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .link_led       (seen.link_led),
        .gps_led        (seen.gps_led),
        .driver_led     (seen.driver_led),
        .buzzer_on      (seen.buzzer_on),
        .hired_power    (seen.hired_power),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------
    // sequencer predictor state, mirrors the block after reset
    // ------------------------------------------------------------------
    logic [2:0]         blink_cnt   = '0;
    logic [2:0]         chirp_cnt   = '0;
    logic [6:0]         long_cnt    = '0;
    logic [2:0]         armed_pat   = PAT_STARTED;
    logic [LEVEL_W-1:0] level_now   = BUZZER_LEVEL_RESET;
    indicators_t        lamps       = '0;

    item_t       pending_q[$];     // items waiting for the driver
    indicators_t lamps_due_q[$];   // predicted indicator states, oldest first

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    logic in_took       = 1'b0;
    bit  steady_flow    = 1'b0;    // no random gaps on either side
    int  hold_requests  = 0;
    int  holds_served   = 0;
    int  hold_left      = 0;

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // buzzer pattern engine, only runs on a tick with a nonzero level
    task automatic step_buzzer(input logic tm);
        case (armed_pat)
            PAT_IDLE: begin
                if (!tm) lamps.buzzer_on = 1'b0;
            end
            PAT_STARTING, PAT_LOGIN: begin
                if (chirp_cnt <= 3'd2) lamps.buzzer_on = 1'b1;
                else if (chirp_cnt == 3'd3) begin
                    lamps.buzzer_on = 1'b0;
                    armed_pat = PAT_IDLE;
                end
            end
            PAT_STARTED: begin
                if (chirp_cnt == 3'd0 || chirp_cnt == 3'd2) lamps.buzzer_on = 1'b1;
                else if (chirp_cnt == 3'd1) lamps.buzzer_on = 1'b0;
                else if (chirp_cnt == 3'd3) begin
                    lamps.buzzer_on = 1'b0;
                    armed_pat = PAT_IDLE;
                end
            end
            PAT_OVERSPEED: lamps.buzzer_on = (long_cnt % 7 == 0);
            PAT_OVERTIME:
                lamps.buzzer_on = (long_cnt == 7'd0 || long_cnt == 7'd2 ||
                                   long_cnt == 7'd4 || long_cnt == 7'd6);
            PAT_LOGOUT: begin
                if (chirp_cnt == 3'd0 || chirp_cnt == 3'd2 || chirp_cnt == 3'd4)
                    lamps.buzzer_on = 1'b1;
                else if (chirp_cnt == 3'd1 || chirp_cnt == 3'd3)
                    lamps.buzzer_on = 1'b0;
                else if (chirp_cnt == 3'd5) begin
                    lamps.buzzer_on = 1'b0;
                    armed_pat = PAT_IDLE;
                end
            end
            default: ;  // undefined pattern holds the buzzer
        endcase
    endtask

    // apply one accepted item and queue the indicator state it leaves behind
    task automatic advance_sequencer(input item_t it);
        if (it.func == FUNC_LOAD) begin
            chirp_cnt = '0;
            armed_pat = it.pattern;
        end else begin
            if (it.passenger_state == PASS_VACANT) lamps.hired_power = 1'b0;
            else if (it.passenger_state == PASS_HIRED) lamps.hired_power = 1'b1;

            if (it.link_state == LINK_DOWN) begin
                if (it.sim_missing)
                    lamps.link_led = (long_cnt == 7'd0 || long_cnt == 7'd2);
                else if (it.internet_up)
                    lamps.link_led = 1'b1;
                else
                    lamps.link_led = (long_cnt == 7'd0 || long_cnt == 7'd2 ||
                                      long_cnt == 7'd4);
            end else if (it.link_state == LINK_UP) begin
                lamps.link_led = ~blink_cnt[0];
            end

            // power save overrides every gps code, the hold codes included
            if (it.low_power)
                lamps.gps_led = (it.gps_state == GPS_FIX && blink_cnt == 3'd1);
            else if (it.gps_state == GPS_FIX)
                lamps.gps_led = ~blink_cnt[0];
            else if (it.gps_state == GPS_NOFIX)
                lamps.gps_led = 1'b1;

            if (it.login_state == LOGIN_OUT) lamps.driver_led = 1'b0;
            else if (it.login_state == LOGIN_IN) lamps.driver_led = ~blink_cnt[0];

            if (level_now != '0) step_buzzer(it.test_mode);

            blink_cnt = blink_cnt + 3'd1;
            chirp_cnt = chirp_cnt + 3'd1;
            long_cnt  = (int'(long_cnt) + 1 >= LONG_PERIOD) ? 7'd0 : long_cnt + 7'd1;
        end
        lamps_due_q.push_back(lamps);
    endtask

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------
    function automatic item_t random_tick();
        item_t it;
        it      = ITEM_W'($urandom);
        it.func = FUNC_TICK;
        return it;
    endfunction

    function automatic item_t buzzer_cmd(input logic [2:0] pat);
        item_t it;
        it         = ITEM_W'($urandom);
        it.func    = FUNC_LOAD;
        it.pattern = pat;
        return it;
    endfunction

    function automatic item_t status_tick(input logic [1:0] link, input logic sim,
                                          input logic inet, input logic [1:0] gps,
                                          input logic psave, input logic [1:0] login,
                                          input logic [1:0] pass, input logic tm);
        item_t it;
        it                 = random_tick();
        it.link_state      = link;
        it.sim_missing     = sim;
        it.internet_up     = inet;
        it.gps_state       = gps;
        it.low_power       = psave;
        it.login_state     = login;
        it.passenger_state = pass;
        it.test_mode       = tm;
        return it;
    endfunction

    // mostly a command followed by enough ticks to play it out,
    // the rest loose ticks and commands cut short by the next one
    task automatic queue_traffic(input int n);
        int left;
        int run;
        logic [2:0] pat;
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 99) < 70) begin
                pat = 3'($urandom_range(0, 7));
                pending_q.push_back(buzzer_cmd(pat));
                left--;
                if (pat == PAT_OVERSPEED || pat == PAT_OVERTIME)
                    run = $urandom_range(8, 30);
                else
                    run = $urandom_range(4, 10);
            end else begin
                run = $urandom_range(0, 3);
                if ($urandom_range(0, 1) == 0) begin
                    pending_q.push_back(buzzer_cmd(3'($urandom_range(0, 7))));
                    left--;
                end
            end
            repeat (run) pending_q.push_back(random_tick());
            left -= run;
        end
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_q.size() != 0 || in_valid || lamps_due_q.size() != 0);
        // result register latency plus margin
        repeat (4) @(posedge clk);
    endtask

    task automatic set_buzzer_level(input logic [LEVEL_W-1:0] lvl);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lvl;
        do @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // input driver: new transaction only once the last one was taken
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_took)) begin
            if (pending_q.size() != 0 &&
                (steady_flow || $urandom_range(0, 99) >= GAP_PCT)) begin
                offer    <= pending_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output stall: random gaps, or a long hold-off on request
    always @(negedge clk) begin
        if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !steady_flow && ($urandom_range(0, 99) < GAP_PCT);
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on input transactions, check output transactions
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        indicators_t want;
        cycle_count = cycle_count + 1;
        in_took <= in_valid && !in_stall;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) level_now = cfg_data;
            if (in_valid && !in_stall) advance_sequencer(offer);
            if (out_valid && !out_stall) begin
                if (lamps_due_q.size() == 0) begin
                    flag_mismatch("result transaction with nothing expected");
                end else begin
                    want = lamps_due_q.pop_front();
                    if (seen.link_led !== want.link_led)
                        flag_mismatch($sformatf("link_led %b, want %b",
                                                seen.link_led, want.link_led));
                    if (seen.gps_led !== want.gps_led)
                        flag_mismatch($sformatf("gps_led %b, want %b",
                                                seen.gps_led, want.gps_led));
                    if (seen.driver_led !== want.driver_led)
                        flag_mismatch($sformatf("driver_led %b, want %b",
                                                seen.driver_led, want.driver_led));
                    if (seen.buzzer_on !== want.buzzer_on)
                        flag_mismatch($sformatf("buzzer_on %b, want %b",
                                                seen.buzzer_on, want.buzzer_on));
                    if (seen.hired_power !== want.hired_power)
                        flag_mismatch($sformatf("hired_power %b, want %b",
                                                seen.hired_power, want.hired_power));
                end
            end
        end
        // watchdog
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status_led_buzzer_sequencer_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus phases
    // ------------------------------------------------------------------
    initial begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every status branch while the armed started chirp plays out
        pending_q.push_back(status_tick(LINK_DOWN, 1'b1, 1'b0, GPS_NOFIX, 1'b0,
                                        LOGIN_OUT, PASS_VACANT, 1'b0));
        pending_q.push_back(status_tick(LINK_DOWN, 1'b0, 1'b1, GPS_FIX, 1'b0,
                                        LOGIN_IN, PASS_HIRED, 1'b0));
        pending_q.push_back(status_tick(LINK_DOWN, 1'b0, 1'b0, GPS_FIX, 1'b1,
                                        LOGIN_IN, CODE_RSVD2, 1'b0));
        pending_q.push_back(status_tick(LINK_UP, 1'b0, 1'b0, GPS_FIX, 1'b1,
                                        CODE_RSVD3, CODE_RSVD3, 1'b1));
        pending_q.push_back(status_tick(CODE_RSVD2, 1'b1, 1'b1, CODE_RSVD2, 1'b0,
                                        CODE_RSVD2, PASS_VACANT, 1'b0));
        pending_q.push_back(status_tick(CODE_RSVD3, 1'b0, 1'b0, CODE_RSVD3, 1'b1,
                                        LOGIN_OUT, PASS_HIRED, 1'b1));
        // every pattern code, the undefined one included, each with a tick
        for (int p = 0; p < 8; p++) begin
            pending_q.push_back(buzzer_cmd(p[2:0]));
            pending_q.push_back(random_tick());
        end
        pending_q.push_back(buzzer_cmd(PAT_UNDEFINED));
        pending_q.push_back(random_tick());
        wait_drained();

        // receiver holds off while the sender keeps offering, fills the block
        queue_traffic(80);
        hold_requests = hold_requests + 1;
        wait_drained();

        // level 0 freezes the buzzer engine
        set_buzzer_level('0);
        queue_traffic(60);
        wait_drained();

        // back-to-back traffic, no gaps on either side
        set_buzzer_level(LEVEL_W'(1));
        steady_flow = 1'b1;
        queue_traffic(80);
        wait_drained();
        steady_flow = 1'b0;

        set_buzzer_level(BUZZER_LEVEL_RESET);
        queue_traffic(100);
        hold_requests = hold_requests + 1;
        wait_drained();

        set_buzzer_level(LEVEL_W'(3));
        queue_traffic(80);
        wait_drained();

        if (mismatch_count == 0)
            $display("status_led_buzzer_sequencer_top regression: pass");
        else
            $display("status_led_buzzer_sequencer_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
